// File: design/ordered_list_engine_defines.svh
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define OLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ole_pkg.sv
package ole_pkg;

  localparam int unsigned CAPACITY_DEFAULT   = 64;
  localparam int unsigned VALUE_BITS_DEFAULT = 32;

  typedef enum logic [2:0] {
    MODE_APPEND    = 3'd0,
    MODE_INSERT    = 3'd1,
    MODE_GET       = 3'd2,
    MODE_DEL_POS   = 3'd3,
    MODE_DEL_VALUE = 3'd4,
    MODE_CLEAR     = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_RANGE     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } state_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic by_value;   // hit on value match instead of position match
    logic do_insert;  // open a gap at pos and store the request value
    logic do_delete;  // close the gap at the first hit
  } cell_ctl_t;

endpackage

// File: design/ole_cell.sv
module ole_cell #(
  parameter int unsigned CAPACITY   = ole_pkg::CAPACITY_DEFAULT,
  parameter int unsigned VALUE_BITS = ole_pkg::VALUE_BITS_DEFAULT,
  parameter int unsigned INDEX      = 0,
  localparam int unsigned POS_W     = $clog2(CAPACITY + 1)
) (
  input  logic                  clk_i,
  input  ole_pkg::cell_ctl_t    ctl_i,
  input  logic [POS_W-1:0]      pos_i,
  input  logic [POS_W-1:0]      count_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [VALUE_BITS-1:0] lower_i,
  input  logic [VALUE_BITS-1:0] upper_i,
  input  logic                  wave_flag_i,
  input  logic [VALUE_BITS-1:0] wave_value_i,
  output logic [VALUE_BITS-1:0] entry_o,
  output logic                  wave_flag_o,
  output logic [VALUE_BITS-1:0] wave_value_o
);

  localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

  logic [VALUE_BITS-1:0] entry_q, entry_d;
  logic                  wflag_q;
  logic [VALUE_BITS-1:0] wval_q;
  logic                  hit;

  always_comb begin
    if (ctl_i.by_value) begin
      hit = (IDX < count_i) && (entry_q == value_i);
    end else begin
      hit = (IDX == pos_i);
    end
  end

  // wave flag: a hit sits in this cell or in one below it
  assign wave_flag_o  = wflag_q | hit;
  assign wave_value_o = wflag_q ? wval_q : entry_q;
  assign entry_o      = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.do_insert) begin
      if (IDX > pos_i) begin
        entry_d = lower_i;
      end else if (IDX == pos_i) begin
        entry_d = value_i;
      end
    end else if (ctl_i.do_delete && wave_flag_o) begin
      entry_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    wflag_q <= wave_flag_i;
    wval_q  <= wave_value_i;
  end

endmodule

// File: design/ole_ctrl.sv
`include "ordered_list_engine_defines.svh"

module ole_ctrl #(
  parameter int unsigned CAPACITY   = ole_pkg::CAPACITY_DEFAULT,
  parameter int unsigned VALUE_BITS = ole_pkg::VALUE_BITS_DEFAULT,
  localparam int unsigned POS_W     = $clog2(CAPACITY + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            mode_i,
  input  logic [VALUE_BITS-1:0] entry_value_i,
  input  logic [POS_W-1:0]      position_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  ok_o,
  output logic [1:0]            status_o,
  output logic [VALUE_BITS-1:0] result_value_o,
  output logic [POS_W-1:0]      item_count_o,
  output ole_pkg::cell_ctl_t    ctl_o,
  output logic [POS_W-1:0]      pos_o,
  output logic [POS_W-1:0]      count_o,
  output logic [VALUE_BITS-1:0] value_o,
  input  logic                  found_i,
  input  logic [VALUE_BITS-1:0] found_value_i
);

  localparam int unsigned       CNT_W      = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0]  SCAN_LAST  = CNT_W'(CAPACITY - 1);
  localparam logic [POS_W-1:0]  FULL_COUNT = POS_W'(CAPACITY);

  ole_pkg::state_e       state_q, state_d;
  logic [2:0]            mode_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [POS_W-1:0]      pos_q;
  logic [POS_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic                  ok_q;
  ole_pkg::status_e      status_q;
  logic [VALUE_BITS-1:0] result_q;
  logic [POS_W-1:0]      item_count_q;

  logic                  accept, commit, full, out_free;
  logic                  ins_ok, del_ok, needs_scan, res_ok;
  ole_pkg::status_e      res_status;
  logic [VALUE_BITS-1:0] res_value;
  logic [POS_W-1:0]      count_next, cell_pos;

  assign full     = (count_q == FULL_COUNT);
  assign out_free = !out_valid_q || out_ready_i;

  // Request decode against the held request and the current count.
  always_comb begin
    ins_ok     = 1'b0;
    del_ok     = 1'b0;
    needs_scan = 1'b0;
    res_ok     = 1'b0;
    res_status = ole_pkg::STATUS_DONE;
    res_value  = '0;
    count_next = count_q;
    cell_pos   = pos_q;
    case (mode_q)
      ole_pkg::MODE_APPEND: begin
        cell_pos = count_q;
        if (full) begin
          res_status = ole_pkg::STATUS_FULL;
        end else begin
          ins_ok     = 1'b1;
          res_ok     = 1'b1;
          count_next = POS_W'(count_q + 1'b1);
        end
      end
      ole_pkg::MODE_INSERT: begin
        if (pos_q > count_q) begin
          res_status = ole_pkg::STATUS_RANGE;
        end else if (full) begin
          res_status = ole_pkg::STATUS_FULL;
        end else begin
          ins_ok     = 1'b1;
          res_ok     = 1'b1;
          count_next = POS_W'(count_q + 1'b1);
        end
      end
      ole_pkg::MODE_GET: begin
        if (pos_q >= count_q) begin
          res_status = ole_pkg::STATUS_RANGE;
        end else begin
          needs_scan = 1'b1;
          res_ok     = 1'b1;
          res_value  = found_value_i;
        end
      end
      ole_pkg::MODE_DEL_POS: begin
        if (pos_q >= count_q) begin
          res_status = ole_pkg::STATUS_RANGE;
        end else begin
          needs_scan = 1'b1;
          del_ok     = 1'b1;
          res_ok     = 1'b1;
          res_value  = found_value_i;
          count_next = POS_W'(count_q - 1'b1);
        end
      end
      ole_pkg::MODE_DEL_VALUE: begin
        needs_scan = 1'b1;
        if (found_i) begin
          del_ok     = 1'b1;
          res_ok     = 1'b1;
          res_value  = found_value_i;
          count_next = POS_W'(count_q - 1'b1);
        end else begin
          res_status = ole_pkg::STATUS_NOT_FOUND;
        end
      end
      ole_pkg::MODE_CLEAR: begin
        res_ok     = 1'b1;
        count_next = '0;
      end
      default: ;
    endcase
  end

  // A scan request commits only once the search wave has climbed the chain and cnt_q has reached SCAN_LAST.
  assign commit = (state_q == ole_pkg::ST_BUSY) && out_free &&
                  (!needs_scan || (cnt_q == SCAN_LAST));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ole_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ole_pkg::ST_BUSY;
        end
      end
      ole_pkg::ST_BUSY: begin
        if (commit) begin
          state_d = ole_pkg::ST_IDLE;
        end
      end
      default: state_d = ole_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o      = (state_q == ole_pkg::ST_IDLE);
    accept          = in_ready_o && in_valid_i;
    ctl_o.by_value  = (mode_q == ole_pkg::MODE_DEL_VALUE);
    ctl_o.do_insert = commit && ins_ok;
    ctl_o.do_delete = commit && del_ok;
    count_d         = commit ? count_next : count_q;
    out_valid_d     = commit || (out_valid_q && !out_ready_i);
    cnt_d           = cnt_q;
    if (accept) begin
      cnt_d = '0;
    end else if ((state_q == ole_pkg::ST_BUSY) && (cnt_q != SCAN_LAST)) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end
  end

  assign pos_o   = cell_pos;
  assign count_o = count_q;
  assign value_o = value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ole_pkg::ST_IDLE;
      count_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      value_q <= entry_value_i;
      pos_q   <= position_i;
    end
    if (commit) begin
      ok_q         <= res_ok;
      status_q     <= res_status;
      result_q     <= res_value;
      item_count_q <= count_next;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign status_o       = status_q;
  assign result_value_o = result_q;
  assign item_count_o   = item_count_q;

  `OLE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= FULL_COUNT, "entry count above capacity")
  `OLE_ASSERT_NOW(a_ok_means_done, out_valid_q && ok_q, status_q == ole_pkg::STATUS_DONE,
                  "successful result with a failure status")
  `OLE_ASSERT_NEXT(a_count_only_on_commit, !commit, count_q == $past(count_q),
                   "entry count moved without a committed request")
  `OLE_ASSERT_NOW(a_no_insert_and_delete, 1'b1, !(ctl_o.do_insert && ctl_o.do_delete),
                  "cells told to insert and delete at once")

endmodule

// File: design/ordered_list_engine.sv
// Ordered list of up to CAPACITY words held in a chain of cells, one entry
// per cell. Requests: append, insert at a position, get, delete at a
// position, delete of the first equal value, clear; one result per request.
// Append, insert, clear and every request that fails its range or full check
// commit without a search, since all cells shift at once. Get, delete at a
// position and delete by value wait for a search wave that walks up the
// chain one cell per clock; the hit is read at the top end. The next
// request is accepted in the cycle after a result is registered, while that
// result may still wait in the output register; a stalled output holds the
// following request in the busy state.
module ordered_list_engine #(
  parameter int unsigned CAPACITY   = ole_pkg::CAPACITY_DEFAULT,
  parameter int unsigned VALUE_BITS = ole_pkg::VALUE_BITS_DEFAULT,
  localparam int unsigned POS_W     = $clog2(CAPACITY + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            mode_i,
  input  logic [VALUE_BITS-1:0] entry_value_i,
  input  logic [POS_W-1:0]      position_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  ok_o,
  output logic [1:0]            status_o,
  output logic [VALUE_BITS-1:0] result_value_o,
  output logic [POS_W-1:0]      item_count_o
);

  ole_pkg::cell_ctl_t    ctl;
  logic [POS_W-1:0]      cell_pos, cell_count;
  logic [VALUE_BITS-1:0] req_value;

  logic [VALUE_BITS-1:0] entry    [CAPACITY];
  logic                  wave_flag[CAPACITY];
  logic [VALUE_BITS-1:0] wave_val [CAPACITY];

  ole_ctrl #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .mode_i,
    .entry_value_i,
    .position_i,
    .out_valid_o,
    .out_ready_i,
    .ok_o,
    .status_o,
    .result_value_o,
    .item_count_o,
    .ctl_o        (ctl),
    .pos_o        (cell_pos),
    .count_o      (cell_count),
    .value_o      (req_value),
    .found_i      (wave_flag[CAPACITY-1]),
    .found_value_i(wave_val[CAPACITY-1])
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_BITS-1:0] lower, upper, wv_in;
    logic                  wf_in;

    if (g == 0) begin : g_first
      assign lower = req_value;
      assign wf_in = 1'b0;
      assign wv_in = '0;
    end else begin : g_mid
      assign lower = entry[g-1];
      assign wf_in = wave_flag[g-1];
      assign wv_in = wave_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign upper = entry[g];
    end else begin : g_inner
      assign upper = entry[g+1];
    end

    ole_cell #(
      .CAPACITY  (CAPACITY),
      .VALUE_BITS(VALUE_BITS),
      .INDEX     (g)
    ) u_cell (
      .clk_i,
      .ctl_i       (ctl),
      .pos_i       (cell_pos),
      .count_i     (cell_count),
      .value_i     (req_value),
      .lower_i     (lower),
      .upper_i     (upper),
      .wave_flag_i (wf_in),
      .wave_value_i(wv_in),
      .entry_o     (entry[g]),
      .wave_flag_o (wave_flag[g]),
      .wave_value_o(wave_val[g])
    );
  end

endmodule

// File: tb/testbench.sv
module testbench;
  import ole_pkg::*;

  localparam int CAP = CAPACITY_DEFAULT;
  localparam int VW  = VALUE_BITS_DEFAULT;
  localparam int PW  = $clog2(CAP + 1);
  localparam int REQUEST_TARGET = 1370;

  typedef struct {
    logic          ok;
    status_e       status;
    logic [VW-1:0] word;
    logic [PW-1:0] count;
  } list_result_t;

  typedef struct {
    mode_e         mode;
    logic [VW-1:0] word;
    logic [PW-1:0] pos;
    int            pace;   // 0 free run, 1 sender idles, 2 receiver stalls, 3 both lightly
    bit            drain;  // hold this request until every result is back
    list_result_t  want;
  } list_request_t;

  logic          clk_i;
  logic          rst_ni;
  logic          req_valid = 1'b0;
  logic          in_ready_o;
  mode_e         req_mode = MODE_APPEND;
  logic [VW-1:0] req_word = '0;
  logic [PW-1:0] req_pos = '0;
  logic          out_valid_o;
  logic          rsp_ready = 1'b0;
  logic          ok_o;
  logic [1:0]    status_o;
  logic [VW-1:0] result_value_o;
  logic [PW-1:0] item_count_o;

  ordered_list_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_valid),
    .in_ready_o    (in_ready_o),
    .mode_i        (req_mode),
    .entry_value_i (req_word),
    .position_i    (req_pos),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (rsp_ready),
    .ok_o          (ok_o),
    .status_o      (status_o),
    .result_value_o(result_value_o),
    .item_count_o  (item_count_o)
  );

  // shadow of the list, advanced in request order
  logic [VW-1:0] list_words [CAP];
  int            list_len = 0;

  list_request_t pending_requests [$];
  list_result_t  expected_results [$];
  list_request_t sending;
  list_result_t  want_now;
  int            total_made = 0;
  int            fail_count = 0;
  int            rx_pace = 0;
  bit            go;

  function automatic logic [VW-1:0] remove_entry(int at);
    logic [VW-1:0] w;
    w = list_words[at];
    for (int c = at; c + 1 < list_len; c++) list_words[c] = list_words[c + 1];
    list_len--;
    return w;
  endfunction

  function automatic list_result_t apply_request(mode_e m, logic [VW-1:0] w, int p);
    list_result_t r;
    int hit;
    r.ok = 1'b0;
    r.status = STATUS_DONE;
    r.word = '0;
    hit = -1;
    case (m)
      MODE_APPEND: begin
        if (list_len >= CAP) r.status = STATUS_FULL;
        else begin
          list_words[list_len] = w;
          list_len++;
          r.ok = 1'b1;
        end
      end
      MODE_INSERT: begin
        // range check wins over the full check
        if (p > list_len) r.status = STATUS_RANGE;
        else if (list_len >= CAP) r.status = STATUS_FULL;
        else begin
          for (int c = list_len; c > p; c--) list_words[c] = list_words[c - 1];
          list_words[p] = w;
          list_len++;
          r.ok = 1'b1;
        end
      end
      MODE_GET: begin
        if (p >= list_len) r.status = STATUS_RANGE;
        else begin
          r.ok = 1'b1;
          r.word = list_words[p];
        end
      end
      MODE_DEL_POS: begin
        if (p >= list_len) r.status = STATUS_RANGE;
        else begin
          r.ok = 1'b1;
          r.word = remove_entry(p);
        end
      end
      MODE_DEL_VALUE: begin
        for (int c = 0; c < list_len; c++)
          if (hit < 0 && list_words[c] == w) hit = c;
        if (hit < 0) r.status = STATUS_NOT_FOUND;
        else begin
          r.ok = 1'b1;
          r.word = remove_entry(hit);
        end
      end
      MODE_CLEAR: begin
        list_len = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.count = PW'(list_len);
    return r;
  endfunction

  task automatic add_request(mode_e m, logic [VW-1:0] w, int p);
    list_request_t q;
    q.mode  = m;
    q.word  = w;
    q.pos   = PW'(p);
    q.pace  = (total_made / 90) % 4;
    q.drain = (total_made == 500 || total_made == 1000);
    q.want  = apply_request(m, w, p);
    pending_requests.push_back(q);
    total_made++;
  endtask

  function automatic logic [VW-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return VW'($urandom_range(15));
      default: return VW'($urandom);
    endcase
  endfunction

  // a value that is in the list most of the time
  function automatic logic [VW-1:0] stored_word();
    if (list_len > 0 && $urandom_range(9) < 8)
      return list_words[$urandom_range(list_len - 1)];
    return pick_word();
  endfunction

  // position for get/delete: mostly valid, sometimes past the end
  function automatic int read_pos();
    if (list_len > 0 && $urandom_range(9) != 0) return $urandom_range(list_len - 1);
    return $urandom_range(CAP, list_len);
  endfunction

  function automatic int write_pos();
    if ($urandom_range(9) != 0) return $urandom_range(list_len);
    return $urandom_range(CAP, list_len);
  endfunction

  task automatic fill_list();
    while (list_len < CAP) begin
      if ($urandom_range(1)) add_request(MODE_APPEND, pick_word(), $urandom_range(CAP));
      else add_request(MODE_INSERT, pick_word(), $urandom_range(list_len));
    end
    add_request(MODE_APPEND, pick_word(), 0);
    add_request(MODE_INSERT, pick_word(), $urandom_range(CAP));
    add_request(MODE_GET, '0, CAP - 1);
    add_request(MODE_GET, '0, CAP);
    add_request(MODE_DEL_POS, '0, CAP - 1);
  endtask

  task automatic empty_list();
    while (list_len > 0) begin
      case ($urandom_range(2))
        0:       add_request(MODE_DEL_POS, pick_word(), $urandom_range(list_len - 1));
        1:       add_request(MODE_DEL_VALUE, list_words[$urandom_range(list_len - 1)],
                             $urandom_range(CAP));
        default: add_request(MODE_GET, pick_word(), $urandom_range(list_len - 1));
      endcase
    end
    add_request(MODE_GET, '0, 0);
    add_request(MODE_DEL_POS, '0, 0);
    add_request(MODE_DEL_VALUE, stored_word(), 0);
  endtask

  task automatic random_request();
    int r;
    r = $urandom_range(99);
    if (r < 25)      add_request(MODE_APPEND, pick_word(), $urandom_range(CAP));
    else if (r < 45) add_request(MODE_INSERT, pick_word(), write_pos());
    else if (r < 66) add_request(MODE_GET, VW'($urandom), read_pos());
    else if (r < 81) add_request(MODE_DEL_POS, VW'($urandom), read_pos());
    else if (r < 98) add_request(MODE_DEL_VALUE, stored_word(), $urandom_range(CAP));
    else             add_request(MODE_CLEAR, VW'($urandom), $urandom_range(CAP));
  endtask

  function automatic int idle_pct(int pace, bit sender);
    if (pace == 3) return 12;
    if (sender && pace == 1) return 74;
    if (!sender && pace == 2) return 74;
    return 0;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    int r;
    rst_ni = 1'b0;

    // corner cases, starting from an empty list
    add_request(MODE_GET, '0, 0);
    add_request(MODE_DEL_POS, '0, 0);
    add_request(MODE_DEL_VALUE, 32'd5, 0);
    add_request(MODE_INSERT, 32'h1, 1);
    add_request(MODE_INSERT, 32'h2, CAP);
    add_request(MODE_APPEND, 32'hffff_ffff, 0);
    add_request(MODE_APPEND, 32'h0, 7'h7f & CAP);
    add_request(MODE_INSERT, 32'h1234_5678, 0);
    add_request(MODE_INSERT, 32'ha5a5_a5a5, 3);
    add_request(MODE_INSERT, 32'h5a5a_5a5a, 5);
    add_request(MODE_GET, '0, 0);
    add_request(MODE_GET, '0, 3);
    add_request(MODE_GET, '0, 4);
    add_request(MODE_GET, '1, CAP);
    add_request(MODE_APPEND, 32'ha5a5_a5a5, 0);
    // duplicate value: lowest position goes first
    add_request(MODE_DEL_VALUE, 32'ha5a5_a5a5, CAP);
    add_request(MODE_DEL_VALUE, 32'h77, 0);
    add_request(MODE_DEL_POS, '0, 1);
    add_request(MODE_DEL_POS, '0, CAP);
    add_request(MODE_GET, '0, 2);
    add_request(MODE_CLEAR, '1, CAP);
    add_request(MODE_GET, '0, 0);

    fill_list();
    empty_list();
    while (total_made < REQUEST_TARGET) begin
      r = $urandom_range(99);
      if (r < 2) fill_list();
      else if (r < 4) empty_list();
      else random_request();
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || expected_results.size() != 0 || req_valid)
      @(posedge clk_i);
    repeat (CAP + 16) @(posedge clk_i);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && in_ready_o) expected_results.push_back(sending.want);
      if (!req_valid || in_ready_o) begin
        go = 1'b0;
        if (pending_requests.size() != 0) begin
          go = $urandom_range(99) >= idle_pct(pending_requests[0].pace, 1'b1);
          if (pending_requests[0].drain && expected_results.size() != 0) go = 1'b0;
        end
        if (go) begin
          sending = pending_requests.pop_front();
          req_valid <= 1'b1;
          req_mode  <= sending.mode;
          req_word  <= sending.word;
          req_pos   <= sending.pos;
          rx_pace   <= sending.pace;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else begin
      if (out_valid_o && rsp_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want_now = expected_results.pop_front();
          if (ok_o !== want_now.ok) begin
            $error("ok: expected %0d, got %0d", want_now.ok, ok_o);
            fail_count++;
          end
          if (status_o !== want_now.status) begin
            $error("status: expected %0d, got %0d", want_now.status, status_o);
            fail_count++;
          end
          if (result_value_o !== want_now.word) begin
            $error("result_value: expected %h, got %h", want_now.word, result_value_o);
            fail_count++;
          end
          if (item_count_o !== want_now.count) begin
            $error("item_count: expected %0d, got %0d", want_now.count, item_count_o);
            fail_count++;
          end
        end
      end
      rsp_ready <= $urandom_range(99) >= idle_pct(rx_pace, 1'b0);
    end
  end

endmodule
